// ===== sv/chtt_pkg.sv =====
// Package with operation codes, empty-entry constants and controller interface types.
`timescale 1ns / 1ps
package chtt_pkg;

  typedef enum logic [1:0] {
    OP_STORE   = 2'd0,
    OP_PROBE   = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  localparam logic [7:0]  EMPTY_DEPTH = 8'hC0;    // -64
  localparam logic [15:0] EMPTY_SCORE = 16'hD8F0; // -10000

  typedef struct packed {
    logic load;
    logic age_inc;
    logic rd;
    logic track;
    logic store_hit;
    logic store_miss;
    logic probe_hit;
    logic clear_wr;
    logic out_load;
  } chtt_cmd_t;

  typedef struct packed {
    logic lock_hit;
  } chtt_status_t;

endpackage

// ===== sv/clustered_two_slot_hash_table.sv =====
// Top level of the clustered two-slot hash table.
// Store and probe scan the cluster ways one at a time (read, then compare), stopping at a
// lock hit or at the last way, then hand the word to the output register.
// Advance age goes straight to the hand-off; clear table sweeps all 2^INDEX_BITS+CLUSTER_WAYS-1 entries.
// After reset the same sweep runs before the first word is taken (65539 entries by default).
// The single-port cluster memory sets the rate; one word is in progress at a time.
`timescale 1ns / 1ps
module clustered_two_slot_hash_table #(
  parameter int INDEX_BITS   = 16,
  parameter int CLUSTER_WAYS = 4,
  parameter int MOVE_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [63:0]        position_hash,
  input  logic [15:0]        new_move,
  input  logic signed [7:0]  new_depth,
  input  logic signed [15:0] new_score,
  input  logic [1:0]         new_node_type,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [15:0]        first_move,
  output logic signed [7:0]  first_depth,
  output logic signed [15:0] first_score,
  output logic [1:0]         first_node_type,
  output logic [15:0]        second_move,
  output logic signed [7:0]  second_depth,
  output logic signed [15:0] second_score,
  output logic [1:0]         second_node_type
);
  import chtt_pkg::*;

  localparam int TABLE_ENTRIES = (2 ** INDEX_BITS) + CLUSTER_WAYS - 1;
  localparam int ADDR_BITS     = $clog2(TABLE_ENTRIES);
  localparam int WAY_BITS      = (CLUSTER_WAYS > 1) ? $clog2(CLUSTER_WAYS) : 1;

  chtt_cmd_t             cmd;
  chtt_status_t          status;
  logic [WAY_BITS-1:0]   way;
  logic [ADDR_BITS-1:0]  clr_addr;

  chtt_ctrl #(
    .CLUSTER_WAYS (CLUSTER_WAYS),
    .ADDR_BITS    (ADDR_BITS),
    .WAY_BITS     (WAY_BITS),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .status   (status),
    .way      (way),
    .clr_addr (clr_addr)
  );

  chtt_datapath #(
    .INDEX_BITS  (INDEX_BITS),
    .CLUSTER_WAYS(CLUSTER_WAYS),
    .MOVE_BITS   (MOVE_BITS),
    .ADDR_BITS   (ADDR_BITS),
    .WAY_BITS    (WAY_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .way             (way),
    .clr_addr        (clr_addr),
    .position_hash   (position_hash),
    .new_move        (new_move),
    .new_depth       (new_depth),
    .new_score       (new_score),
    .new_node_type   (new_node_type),
    .hit             (hit),
    .first_move      (first_move),
    .first_depth     (first_depth),
    .first_score     (first_score),
    .first_node_type (first_node_type),
    .second_move     (second_move),
    .second_depth    (second_depth),
    .second_score    (second_score),
    .second_node_type(second_node_type)
  );

  // Only one word is in progress, so an accepted word closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in progress");

  // A loaded result word stays until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(first_move))
    else $error("result word changed before it was taken");

  // Memory writes never overlap a scan read.
  a_no_rd_wr: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> !(cmd.clear_wr || cmd.store_hit || cmd.store_miss || cmd.probe_hit))
    else $error("read and write issued together");

endmodule

// ===== sv/chtt_datapath.sv =====
// Datapath: cluster memory, replacement scoring, slot update and result registers.
`timescale 1ns / 1ps
module chtt_datapath #(
  parameter int INDEX_BITS   = 16,
  parameter int CLUSTER_WAYS = 4,
  parameter int MOVE_BITS    = 16,
  parameter int ADDR_BITS    = 17,
  parameter int WAY_BITS     = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  chtt_pkg::chtt_cmd_t   cmd,
  output chtt_pkg::chtt_status_t status,
  input  logic [WAY_BITS-1:0]   way,
  input  logic [ADDR_BITS-1:0]  clr_addr,
  input  logic [63:0]           position_hash,
  input  logic [15:0]           new_move,
  input  logic signed [7:0]     new_depth,
  input  logic signed [15:0]    new_score,
  input  logic [1:0]            new_node_type,
  output logic                  hit,
  output logic [15:0]           first_move,
  output logic signed [7:0]     first_depth,
  output logic signed [15:0]    first_score,
  output logic [1:0]            first_node_type,
  output logic [15:0]           second_move,
  output logic signed [7:0]     second_depth,
  output logic signed [15:0]    second_score,
  output logic [1:0]            second_node_type
);
  import chtt_pkg::*;

  localparam int TABLE_ENTRIES = (2 ** INDEX_BITS) + CLUSTER_WAYS - 1;

  typedef struct packed {
    logic [31:0]          lock;
    logic [3:0]           age1;
    logic [3:0]           age2;
    logic [1:0]           nt1;
    logic [1:0]           nt2;
    logic [7:0]           d1;
    logic [7:0]           d2;
    logic [MOVE_BITS-1:0] m1;
    logic [MOVE_BITS-1:0] m2;
    logic [15:0]          s1;
    logic [15:0]          s2;
  } entry_t;

  entry_t               mem [TABLE_ENTRIES];
  entry_t               rdata;
  entry_t               wdata;
  logic [ADDR_BITS-1:0] waddr;
  logic                 we;

  logic [63:0]          hash_q;
  logic [MOVE_BITS-1:0] move_q;
  logic [7:0]           depth_q;
  logic [15:0]          score_q;
  logic [1:0]           nt_q;
  logic [3:0]           current_age;

  logic signed [13:0]   best_s;
  logic [WAY_BITS-1:0]  best_way;
  logic [3:0]           age_gap;
  logic signed [13:0]   s_now;
  logic                 better;
  logic [WAY_BITS-1:0]  final_way;
  logic [ADDR_BITS-1:0] base;
  logic [ADDR_BITS-1:0] way_addr;
  logic [ADDR_BITS-1:0] miss_addr;
  logic                 deep_ok;
  logic [31:0]          m1_wide;
  logic [31:0]          m2_wide;

  logic                 res_hit;
  logic [15:0]          res_m1, res_m2, res_s1, res_s2;
  logic [7:0]           res_d1, res_d2;
  logic [1:0]           res_nt1, res_nt2;

  assign base      = ADDR_BITS'(hash_q[INDEX_BITS-1:0]);
  assign way_addr  = base + ADDR_BITS'(way);
  assign age_gap   = current_age - rdata.age1;
  assign s_now     = $signed({2'b00, age_gap, 8'h00}) - $signed({{6{rdata.d1[7]}}, rdata.d1});
  assign better    = (way == '0) || (s_now > best_s);
  assign final_way = better ? way : best_way;
  assign miss_addr = base + ADDR_BITS'(final_way);
  assign deep_ok   = $signed(rdata.d2) <= $signed(depth_q);
  assign m1_wide   = 32'(rdata.m1);
  assign m2_wide   = 32'(rdata.m2);
  assign status.lock_hit = (rdata.lock == hash_q[63:32]);

  always_comb begin
    we    = 1'b0;
    waddr = way_addr;
    wdata = rdata;
    if (cmd.clear_wr) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '{lock: 32'd0, age1: 4'd0, age2: 4'd0, nt1: 2'd0, nt2: 2'd0,
                d1: EMPTY_DEPTH, d2: EMPTY_DEPTH, m1: '0, m2: '0,
                s1: EMPTY_SCORE, s2: EMPTY_SCORE};
    end else if (cmd.store_miss) begin
      we    = 1'b1;
      waddr = miss_addr;
      wdata = '{lock: hash_q[63:32], age1: current_age, age2: current_age,
                nt1: nt_q, nt2: nt_q, d1: depth_q, d2: depth_q, m1: move_q,
                m2: move_q, s1: score_q, s2: score_q};
    end else if (cmd.store_hit) begin
      we         = 1'b1;
      wdata.age1 = current_age;
      wdata.nt1  = nt_q;
      wdata.d1   = depth_q;
      wdata.m1   = move_q;
      wdata.s1   = score_q;
      if (deep_ok) begin
        wdata.age2 = current_age;
        wdata.nt2  = nt_q;
        wdata.d2   = depth_q;
        wdata.m2   = move_q;
        wdata.s2   = score_q;
      end
    end else if (cmd.probe_hit) begin
      we         = 1'b1;
      wdata.age1 = current_age;
      wdata.age2 = current_age;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[way_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_age <= 4'd0;
    end else if (cmd.age_inc) begin
      current_age <= current_age + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hash_q  <= position_hash;
      move_q  <= MOVE_BITS'(32'(new_move));
      depth_q <= new_depth;
      score_q <= new_score;
      nt_q    <= new_node_type;
    end
    if (cmd.track && better) begin
      best_s   <= s_now;
      best_way <= way;
    end
    if (cmd.load) begin
      res_hit <= 1'b0;
      res_m1  <= '0;
      res_m2  <= '0;
      res_d1  <= '0;
      res_d2  <= '0;
      res_s1  <= '0;
      res_s2  <= '0;
      res_nt1 <= '0;
      res_nt2 <= '0;
    end else if (cmd.probe_hit) begin
      res_hit <= 1'b1;
      res_m1  <= m1_wide[15:0];
      res_m2  <= m2_wide[15:0];
      res_d1  <= rdata.d1;
      res_d2  <= rdata.d2;
      res_s1  <= rdata.s1;
      res_s2  <= rdata.s2;
      res_nt1 <= rdata.nt1;
      res_nt2 <= rdata.nt2;
    end
    if (cmd.out_load) begin
      hit              <= res_hit;
      first_move       <= res_m1;
      first_depth      <= res_d1;
      first_score      <= res_s1;
      first_node_type  <= res_nt1;
      second_move      <= res_m2;
      second_depth     <= res_d2;
      second_score     <= res_s2;
      second_node_type <= res_nt2;
    end
  end

endmodule

// ===== sv/chtt_ctrl.sv =====
// Controller: sequences clearing sweeps, cluster way scans and result hand-off.
`timescale 1ns / 1ps
module chtt_ctrl #(
  parameter int CLUSTER_WAYS  = 4,
  parameter int ADDR_BITS     = 17,
  parameter int WAY_BITS      = 2,
  parameter int TABLE_ENTRIES = 65539
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             op,
  output logic                   out_valid,
  input  logic                   out_ready,
  output chtt_pkg::chtt_cmd_t    cmd,
  input  chtt_pkg::chtt_status_t status,
  output logic [WAY_BITS-1:0]    way,
  output logic [ADDR_BITS-1:0]   clr_addr
);
  import chtt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(TABLE_ENTRIES - 1);
  localparam logic [WAY_BITS-1:0]  LAST_WAY  = WAY_BITS'(CLUSTER_WAYS - 1);

  state_t state;
  op_t    op_q;
  logic   pend_result;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_CLEAR: cmd.clear_wr = 1'b1;
      S_IDLE: begin
        cmd.load    = accept;
        cmd.age_inc = accept && (op_t'(op) == OP_ADVANCE);
      end
      S_READ: cmd.rd = 1'b1;
      S_CHECK: begin
        cmd.track      = !status.lock_hit;
        cmd.store_hit  = status.lock_hit && (op_q == OP_STORE);
        cmd.probe_hit  = status.lock_hit && (op_q == OP_PROBE);
        cmd.store_miss = !status.lock_hit && (way == LAST_WAY) && (op_q == OP_STORE);
      end
      S_DONE: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      op_q        <= OP_STORE;
      pend_result <= 1'b0;
      way         <= '0;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == LAST_ADDR) begin
            clr_addr <= '0;
            state    <= pend_result ? S_DONE : S_IDLE;
          end else begin
            clr_addr <= clr_addr + ADDR_BITS'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q <= op_t'(op);
            way  <= '0;
            unique case (op_t'(op))
              OP_STORE, OP_PROBE: state <= S_READ;
              OP_ADVANCE:         state <= S_DONE;
              OP_CLEAR: begin
                pend_result <= 1'b1;
                clr_addr    <= '0;
                state       <= S_CLEAR;
              end
              default:            state <= S_DONE;
            endcase
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (status.lock_hit || way == LAST_WAY) begin
            state <= S_DONE;
          end else begin
            way   <= way + WAY_BITS'(1);
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            pend_result <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
